// File: hdl/circular_linked_list_manager_unit_macros.svh
// Assertion macros for the circular linked list manager unit.
// Used by cllm_ctrl; expects signals named clk and rst in the including scope.
`ifndef CIRCULAR_LINKED_LIST_MANAGER_UNIT_MACROS_SVH
`define CIRCULAR_LINKED_LIST_MANAGER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define CLLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CLLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CLLM_ASSERT(lbl, prop, msg)
`define CLLM_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/cllm_pkg.sv
// Shared types and codes for the circular linked list manager.
// No dependencies.
`default_nettype none
package cllm_pkg;

  localparam int ENTRIES_DEFAULT = 256;
  localparam int HANDLE_W        = 8;
  localparam int OP_W            = 4;
  localparam int STATUS_W        = 2;

  localparam logic [OP_W-1:0] OP_PUSH_L     = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_R     = 4'd1;
  localparam logic [OP_W-1:0] OP_POP_L      = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_R      = 4'd3;
  localparam logic [OP_W-1:0] OP_PEEK_L     = 4'd4;
  localparam logic [OP_W-1:0] OP_PEEK_R     = 4'd5;
  localparam logic [OP_W-1:0] OP_INS_AFTER  = 4'd6;
  localparam logic [OP_W-1:0] OP_INS_BEFORE = 4'd7;
  localparam logic [OP_W-1:0] OP_REMOVE     = 4'd8;
  localparam logic [OP_W-1:0] OP_IS_EMPTY   = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERR   = 2'd2;

  typedef struct packed {
    logic                key_present;
    logic [HANDLE_W-1:0] key;
    logic [HANDLE_W-1:0] node;
    logic [OP_W-1:0]     operation;
  } cmd_t;

  typedef struct packed {
    logic                list_empty;
    logic                handle_valid;
    logic [HANDLE_W-1:0] handle_out;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/cllm_ram.sv
// Generic RAM: one write port, two registered read ports.
// Depends on cllm_pkg for the default depth.
`default_nettype none
module cllm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = cllm_pkg::ENTRIES_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// File: hdl/cllm_ctrl.sv
// Sequencer for the list manager: reads links, decides, writes back in two passes.
// Depends on cllm_pkg and the assertion macro header; drives two cllm_ram instances.
`default_nettype none
`include "circular_linked_list_manager_unit_macros.svh"
module cllm_ctrl #(
  parameter int ENTRIES = cllm_pkg::ENTRIES_DEFAULT,
  localparam int AW = $clog2(ENTRIES),
  localparam int LW = $clog2(ENTRIES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cllm_pkg::cmd_t  in_cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cllm_pkg::result_t    out_res,
  output logic                 nxt_we,
  output logic [AW-1:0]        nxt_waddr,
  output logic [LW-1:0]        nxt_wdata,
  output logic                 prv_we,
  output logic [AW-1:0]        prv_waddr,
  output logic [LW-1:0]        prv_wdata,
  output logic [AW-1:0]        rd_addr_a,
  output logic [AW-1:0]        rd_addr_b,
  input  wire logic [LW-1:0]   nxt_rdata_a,
  input  wire logic [LW-1:0]   nxt_rdata_b,
  input  wire logic [LW-1:0]   prv_rdata_a,
  input  wire logic [LW-1:0]   prv_rdata_b
);

  localparam logic [LW-1:0] LINK_NULL = LW'(ENTRIES);
  localparam logic [AW-1:0] LAST_IDX  = AW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state;
  logic          clearing;
  logic [AW-1:0] clr_cnt;
  logic [LW-1:0] head, tail;
  cllm_pkg::cmd_t    cmd_r;
  cllm_pkg::result_t res_r;
  cllm_pkg::result_t out_res_next;
  logic              out_valid_next;

  // second write pass, held through the final state
  logic          n_we2_r, p_we2_r;
  logic [AW-1:0] n_a2_r, p_a2_r;
  logic [LW-1:0] n_d2_r, p_d2_r;

  logic accept;
  logic [AW+cllm_pkg::HANDLE_W-1:0] in_node_ext, in_key_ext;

  assign accept      = in_valid && in_ready;
  assign in_ready    = (state == S_IDLE) && !clearing;
  assign in_node_ext = {{AW{1'b0}}, in_cmd.node};
  assign in_key_ext  = {{AW{1'b0}}, in_cmd.key};

  always_comb begin
    case (in_cmd.operation)
      cllm_pkg::OP_POP_L: rd_addr_a = head[AW-1:0];
      cllm_pkg::OP_POP_R: rd_addr_a = tail[AW-1:0];
      default:            rd_addr_a = in_node_ext[AW-1:0];
    endcase
    rd_addr_b = in_key_ext[AW-1:0];
  end

  // Decision logic, valid in S_EXEC when link read data is available
  logic [LW+cllm_pkg::HANDLE_W-1:0] node_lext, key_lext;
  logic [LW-1:0] node_link, key_link;
  logic node_ok, key_ok, node_linked, key_linked, is_empty;

  assign node_lext   = {{LW{1'b0}}, cmd_r.node};
  assign key_lext    = {{LW{1'b0}}, cmd_r.key};
  assign node_link   = node_lext[LW-1:0];
  assign key_link    = key_lext[LW-1:0];
  assign node_ok     = {24'b0, cmd_r.node} < 32'(ENTRIES);
  assign key_ok      = {24'b0, cmd_r.key} < 32'(ENTRIES);
  assign node_linked = (nxt_rdata_a != LINK_NULL) || (prv_rdata_a != LINK_NULL);
  assign key_linked  = (nxt_rdata_b != LINK_NULL) || (prv_rdata_b != LINK_NULL);
  assign is_empty    = (head == LINK_NULL);

  logic          do_push, push_left, do_ins, do_unlink, hv;
  logic [LW-1:0] sp_a, sp_b, ul_h, hsel, head_next, tail_next;
  logic [LW+cllm_pkg::HANDLE_W-1:0] hext;
  logic [cllm_pkg::STATUS_W-1:0] status;
  logic          n_we1, p_we1, n_we2, p_we2;
  logic [AW-1:0] n_a1, p_a1, n_a2, p_a2;
  logic [LW-1:0] n_d1, p_d1, n_d2, p_d2;

  always_comb begin
    do_push   = 1'b0;
    push_left = 1'b0;
    do_ins    = 1'b0;
    do_unlink = 1'b0;
    hv        = 1'b0;
    hsel      = '0;
    sp_a      = tail;
    sp_b      = head;
    ul_h      = node_link;
    status    = cllm_pkg::ST_OK;
    head_next = head;
    tail_next = tail;
    n_we1 = 1'b0; n_a1 = '0; n_d1 = '0;
    p_we1 = 1'b0; p_a1 = '0; p_d1 = '0;
    n_we2 = 1'b0; n_a2 = '0; n_d2 = '0;
    p_we2 = 1'b0; p_a2 = '0; p_d2 = '0;

    case (cmd_r.operation)
      cllm_pkg::OP_PUSH_L: begin
        do_push   = 1'b1;
        push_left = 1'b1;
      end
      cllm_pkg::OP_PUSH_R: begin
        do_push = 1'b1;
      end
      cllm_pkg::OP_POP_L, cllm_pkg::OP_POP_R, cllm_pkg::OP_PEEK_L,
      cllm_pkg::OP_PEEK_R: begin
        if (is_empty) begin
          status = cllm_pkg::ST_EMPTY;
        end else begin
          hv   = 1'b1;
          hsel = (cmd_r.operation == cllm_pkg::OP_POP_L ||
                  cmd_r.operation == cllm_pkg::OP_PEEK_L) ? head : tail;
          ul_h = hsel;
          do_unlink = (cmd_r.operation == cllm_pkg::OP_POP_L ||
                       cmd_r.operation == cllm_pkg::OP_POP_R);
        end
      end
      cllm_pkg::OP_INS_AFTER, cllm_pkg::OP_INS_BEFORE: begin
        if (!cmd_r.key_present) begin
          do_push   = 1'b1;
          push_left = (cmd_r.operation == cllm_pkg::OP_INS_BEFORE);
        end else if (!node_ok || !key_ok || node_linked || !key_linked) begin
          status = cllm_pkg::ST_ERR;
        end else if (cmd_r.operation == cllm_pkg::OP_INS_AFTER) begin
          do_ins = 1'b1;
          sp_a   = key_link;
          sp_b   = nxt_rdata_b;
          if (tail == key_link) begin
            tail_next = node_link;
          end
        end else begin
          do_ins = 1'b1;
          sp_a   = prv_rdata_b;
          sp_b   = key_link;
          if (head == key_link) begin
            head_next = node_link;
          end
        end
      end
      cllm_pkg::OP_REMOVE: begin
        if (!node_ok || !node_linked) begin
          status = cllm_pkg::ST_ERR;
        end else begin
          do_unlink = 1'b1;
        end
      end
      cllm_pkg::OP_IS_EMPTY: begin
      end
      default: begin
        status = cllm_pkg::ST_ERR;
      end
    endcase

    if (do_push) begin
      if (!node_ok || node_linked) begin
        status = cllm_pkg::ST_ERR;
      end else if (is_empty) begin
        // first entry links to itself
        n_we1 = 1'b1; n_a1 = node_link[AW-1:0]; n_d1 = node_link;
        p_we1 = 1'b1; p_a1 = node_link[AW-1:0]; p_d1 = node_link;
        head_next = node_link;
        tail_next = node_link;
      end else begin
        do_ins = 1'b1;
        if (push_left) begin
          head_next = node_link;
        end else begin
          tail_next = node_link;
        end
      end
    end

    // splice node between sp_a and sp_b (sp_a.next == sp_b)
    if (do_ins) begin
      n_we1 = 1'b1; n_a1 = sp_a[AW-1:0];      n_d1 = node_link;
      p_we1 = 1'b1; p_a1 = sp_b[AW-1:0];      p_d1 = node_link;
      n_we2 = 1'b1; n_a2 = node_link[AW-1:0]; n_d2 = sp_b;
      p_we2 = 1'b1; p_a2 = node_link[AW-1:0]; p_d2 = sp_a;
    end

    if (do_unlink) begin
      if (nxt_rdata_a == ul_h) begin
        head_next = LINK_NULL;
        tail_next = LINK_NULL;
        n_we1 = 1'b1; n_a1 = ul_h[AW-1:0]; n_d1 = LINK_NULL;
        p_we1 = 1'b1; p_a1 = ul_h[AW-1:0]; p_d1 = LINK_NULL;
      end else begin
        n_we1 = 1'b1; n_a1 = prv_rdata_a[AW-1:0]; n_d1 = nxt_rdata_a;
        p_we1 = 1'b1; p_a1 = nxt_rdata_a[AW-1:0]; p_d1 = prv_rdata_a;
        n_we2 = 1'b1; n_a2 = ul_h[AW-1:0];        n_d2 = LINK_NULL;
        p_we2 = 1'b1; p_a2 = ul_h[AW-1:0];        p_d2 = LINK_NULL;
        if (head == ul_h) begin
          head_next = nxt_rdata_a;
        end else if (tail == ul_h) begin
          tail_next = prv_rdata_a;
        end
      end
    end
  end

  assign hext = {{cllm_pkg::HANDLE_W{1'b0}}, hsel};

  // RAM write port muxes: clearing sweep, first pass, second pass
  always_comb begin
    nxt_we = 1'b0; nxt_waddr = clr_cnt; nxt_wdata = LINK_NULL;
    prv_we = 1'b0; prv_waddr = clr_cnt; prv_wdata = LINK_NULL;
    if (clearing) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end else if (state == S_EXEC) begin
      nxt_we = n_we1; nxt_waddr = n_a1; nxt_wdata = n_d1;
      prv_we = p_we1; prv_waddr = p_a1; prv_wdata = p_d1;
    end else if (state == S_FIN) begin
      // repeated while the output is stalled; the writes are idempotent
      nxt_we = n_we2_r; nxt_waddr = n_a2_r; nxt_wdata = n_d2_r;
      prv_we = p_we2_r; prv_waddr = p_a2_r; prv_wdata = p_d2_r;
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    out_res_next   = out_res;
    if (state == S_FIN && out_free) begin
      out_valid_next = 1'b1;
      out_res_next   = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      head      <= LINK_NULL;
      tail      <= LINK_NULL;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == LAST_IDX) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          head  <= head_next;
          tail  <= tail_next;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_res <= out_res_next;
    if (accept) begin
      cmd_r <= in_cmd;
    end
    if (state == S_EXEC) begin
      res_r.status       <= status;
      res_r.handle_out   <= hv ? hext[cllm_pkg::HANDLE_W-1:0] : '0;
      res_r.handle_valid <= hv;
      res_r.list_empty   <= (head_next == LINK_NULL);
      n_we2_r <= n_we2; n_a2_r <= n_a2; n_d2_r <= n_d2;
      p_we2_r <= p_we2; p_a2_r <= p_a2; p_d2_r <= p_d2;
    end
  end

  `CLLM_ASSERT(a_head_tail_null, (head == LINK_NULL) == (tail == LINK_NULL), "head/tail null mismatch")
  `CLLM_ASSERT_IMP(a_accept_exec, accept, ##1 (state == S_EXEC), "accept did not start update")
  `CLLM_ASSERT_IMP(a_load_from_fin, $rose(out_valid), $past(state) == S_FIN, "result loaded outside final state")
  `CLLM_ASSERT(a_no_clear_busy, !(clearing && state != S_IDLE), "item in flight during clear sweep")
  `CLLM_ASSERT_IMP(a_fin_stall_holds, (state == S_FIN) && !out_free, ##1 (state == S_FIN), "final state left while output stalled")

endmodule
`default_nettype wire

// File: hdl/circular_linked_list_manager_unit.sv
// Circular doubly linked list manager over a pool of ENTRIES handles.
// Result: m_axis_tvalid is registered in S_FIN, after S_EXEC, once the output is free.
// Each accepted item passes accept/read, update with first link writes, and second
// link writes, set by the single write port of each link RAM; no new input beat is
// taken until the item has left S_FIN. Reset: rst clears head/tail, then a sweep
// writes null to every link entry; s_axis_tready stays low during the sweep.
`default_nettype none
module circular_linked_list_manager_unit #(
  parameter int ENTRIES = cllm_pkg::ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // node[7:0], key[15:8]
  input  wire logic [4:0]  s_axis_tuser,  // operation[3:0], key_present[4]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // handle_out[7:0]
  output logic [3:0]       m_axis_tuser   // status[1:0], handle_valid[2], list_empty[3]
);

  localparam int AW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);

  cllm_pkg::cmd_t    cmd;
  cllm_pkg::result_t res;

  logic          nxt_we, prv_we;
  logic [AW-1:0] nxt_waddr, prv_waddr, rd_addr_a, rd_addr_b;
  logic [LW-1:0] nxt_wdata, prv_wdata;
  logic [LW-1:0] nxt_rdata_a, nxt_rdata_b, prv_rdata_a, prv_rdata_b;

  assign cmd.operation   = s_axis_tuser[3:0];
  assign cmd.key_present = s_axis_tuser[4];
  assign cmd.node        = s_axis_tdata[7:0];
  assign cmd.key         = s_axis_tdata[15:8];

  assign m_axis_tdata = res.handle_out;
  assign m_axis_tuser = {res.list_empty, res.handle_valid, res.status};

  cllm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next_ram (
    .clk     (clk),
    .we      (nxt_we),
    .waddr   (nxt_waddr),
    .wdata   (nxt_wdata),
    .raddr_a (rd_addr_a),
    .rdata_a (nxt_rdata_a),
    .raddr_b (rd_addr_b),
    .rdata_b (nxt_rdata_b)
  );

  cllm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_prev_ram (
    .clk     (clk),
    .we      (prv_we),
    .waddr   (prv_waddr),
    .wdata   (prv_wdata),
    .raddr_a (rd_addr_a),
    .rdata_a (prv_rdata_a),
    .raddr_b (rd_addr_b),
    .rdata_b (prv_rdata_b)
  );

  cllm_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_cmd      (cmd),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_res     (res),
    .nxt_we      (nxt_we),
    .nxt_waddr   (nxt_waddr),
    .nxt_wdata   (nxt_wdata),
    .prv_we      (prv_we),
    .prv_waddr   (prv_waddr),
    .prv_wdata   (prv_wdata),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .nxt_rdata_a (nxt_rdata_a),
    .nxt_rdata_b (nxt_rdata_b),
    .prv_rdata_a (prv_rdata_a),
    .prv_rdata_b (prv_rdata_b)
  );

endmodule
`default_nettype wire
